// File: rtl/th2c_pkg.sv
// shared constants and helpers for the hit to cartesian converter
`timescale 1ns / 1ps

package th2c_pkg;

    // item kinds carried on the input tuser
    localparam logic [1:0] ACT_CONVERT  = 2'd0;
    localparam logic [1:0] ACT_ROW_LOAD = 2'd1;
    localparam logic [1:0] ACT_SEC_LOAD = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_Z_OFFSET     = 2'd0;
    localparam logic [1:0] REG_DRIFT_LENGTH = 2'd1;
    localparam logic [1:0] REG_TIME_SCALE   = 2'd2;

    // geometry limits
    localparam int ROW_SLOTS_DEF = 64;
    localparam int PADROW_W      = 7;
    localparam int SECTOR_W      = 6;
    localparam int SECTOR_SLOTS  = 12;
    localparam int SLOT_W        = 4;
    localparam logic [SECTOR_W-1:0] SECTOR_MAX   = 6'd24;
    localparam logic [SECTOR_W-1:0] SECTOR_HALF  = 6'd12;
    localparam logic [SECTOR_W-1:0] SECTOR_LAST  = 6'd24;
    localparam logic [SECTOR_W-1:0] SECTOR_FLIP  = 6'd23;
    localparam logic [SLOT_W-1:0]   SLOT_LAST    = 4'd11;

    // code / 100 by reciprocal: floor(code * 5243 / 2^19), exact below 4096
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [6:0]  ROWS_PER_SEC = 7'd100;

    // field widths
    localparam int CODE_W   = 12;
    localparam int POS_W    = 16;
    localparam int IDX_W    = 6;
    localparam int OFF_W    = 16;
    localparam int CNT_W    = 8;
    localparam int PITCH_W  = 16;
    localparam int TRIG_W   = 16;
    localparam int ID_W     = 16;
    localparam int OUT_W    = 24;
    localparam int ZOFF_W   = 24;
    localparam int DRIFT_W  = 23;
    localparam int SCALE_W  = 20;
    localparam int CFG_W    = 24;
    localparam int ROW_DATA_W = OFF_W + CNT_W + PITCH_W;

    // bus widths
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 104;

    // datapath widths
    localparam int FAC_W   = 18;               // pad - half*64 + 32
    localparam int XL_W    = 35;               // local x in 2^-22 cm
    localparam int PX_W    = XL_W + TRIG_W;    // trig * local x
    localparam int PY_W    = OFF_W + 1 + TRIG_W;  // trig * row offset
    localparam int XG_W    = PX_W + 1;         // rotated sum in 2^-37 cm
    localparam int ZB_W    = ZOFF_W + 1;       // z offset + drift length
    localparam int TP_W    = POS_W + SCALE_W;  // time * scale
    localparam int Z_W     = 41;               // z in 2^-22 cm
    localparam int XY_SH   = 29;
    localparam int Z_SH    = 14;
    localparam int YL_SH   = 14;
    localparam int SAT_W   = 64;

    localparam logic signed [SAT_W-1:0] OUT_MAX_W = SAT_W'(8388607);
    localparam logic signed [SAT_W-1:0] OUT_MIN_W = -SAT_W'(8388608);

    // clamp a wide signed value to the 24 bit output range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] c;
        c = v;
        if (v > OUT_MAX_W) begin
            c = OUT_MAX_W;
        end
        if (v < OUT_MIN_W) begin
            c = OUT_MIN_W;
        end
        return c[OUT_W-1:0];
    endfunction

endpackage

// File: rtl/tpc_hit_to_cartesian_core.sv
// hit to cartesian converter top level: table loads, decode, rotation, z and rounding
// path: a convert request is registered in stages 1 to 5 and then in the output register
// throughput: one request per cycle while the output is not stalled; six register stages with per-stage valid
// bits, each stage advancing when the one after it is empty or moving
// reset: synchronous active low aresetn clears valids, hit counter and config registers;
// geometry tables are not cleared and must be loaded before use
`timescale 1ns / 1ps

module tpc_hit_to_cartesian_core import th2c_pkg::*; #(
    parameter int ROW_SLOTS = ROW_SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // row_code, pad_pos, time_pos, table_index, row_offset, pad_count,
    // pad_pitch, sine_val, cosine_val, zero fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // action
    input  logic [1:0]           s_axis_tuser,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // hit_id, row_out, x_pos, y_pos, z_pos, zero fill
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // range_error
    output logic [0:0]           m_axis_tuser
);

    localparam int ROW_AW = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
    localparam logic [PADROW_W-1:0] ROW_LIM = PADROW_W'(ROW_SLOTS);

    // ------------------------------------------------------------------
    // configuration registers
    logic signed [ZOFF_W-1:0] z_off_reg;
    logic [DRIFT_W-1:0]       drift_reg;
    logic [SCALE_W-1:0]       scale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            z_off_reg <= '0;
            drift_reg <= '0;
            scale_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_Z_OFFSET:     z_off_reg <= cfg_data[ZOFF_W-1:0];
                REG_DRIFT_LENGTH: drift_reg <= cfg_data[DRIFT_W-1:0];
                REG_TIME_SCALE:   scale_reg <= cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage handshake: each stage loads when empty or when the next one loads
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, m_valid_reg;
    logic r1, r2, r3, r4, r5, r_out;

    assign r_out = !m_valid_reg || m_axis_tready;
    assign r5    = !v5_reg || r_out;
    assign r4    = !v4_reg || r5;
    assign r3    = !v3_reg || r4;
    assign r2    = !v2_reg || r3;
    assign r1    = !v1_reg || r2;
    assign s_axis_tready = r1;

    // ------------------------------------------------------------------
    // stage 1: input register
    logic [1:0]               act_reg;
    logic [CODE_W-1:0]        code1_reg;
    logic [POS_W-1:0]         pad1_reg;
    logic [POS_W-1:0]         tim1_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [OFF_W-1:0]         ld_off_reg;
    logic [CNT_W-1:0]         ld_cnt_reg;
    logic [PITCH_W-1:0]       ld_pitch_reg;
    logic signed [TRIG_W-1:0] ld_sin_reg;
    logic signed [TRIG_W-1:0] ld_cos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (r1) begin
            v1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (r1) begin
            act_reg      <= s_axis_tuser;
            code1_reg    <= s_axis_tdata[11:0];
            pad1_reg     <= s_axis_tdata[27:12];
            tim1_reg     <= s_axis_tdata[43:28];
            idx_reg      <= s_axis_tdata[49:44];
            ld_off_reg   <= s_axis_tdata[65:50];
            ld_cnt_reg   <= s_axis_tdata[73:66];
            ld_pitch_reg <= s_axis_tdata[89:74];
            ld_sin_reg   <= s_axis_tdata[105:90];
            ld_cos_reg   <= s_axis_tdata[121:106];
        end
    end

    // row code split into sector and padrow
    logic [CODE_W+12:0]   div_prod;
    logic [SECTOR_W-1:0]  sector;
    logic [CODE_W-1:0]    sec_rows;
    logic [CODE_W-1:0]    pad_rem;
    logic [PADROW_W-1:0]  padrow;
    logic [PADROW_W-1:0]  row_idx;
    logic [SECTOR_W-1:0]  slot_wide;
    logic [SLOT_W-1:0]    slot_next;
    logic                 bad_next;
    logic                 neg_next;

    assign div_prod = (CODE_W+13)'(code1_reg) * (CODE_W+13)'(DIV100_MUL);
    assign sector   = div_prod[DIV100_SHIFT +: SECTOR_W];
    assign sec_rows = CODE_W'(sector) * CODE_W'(ROWS_PER_SEC);
    assign pad_rem  = code1_reg - sec_rows;
    assign padrow   = pad_rem[PADROW_W-1:0];
    assign row_idx  = padrow - PADROW_W'(1);
    assign bad_next = (sector == '0) || (sector > SECTOR_MAX) ||
                      (padrow == '0) || (padrow > ROW_LIM);
    assign neg_next = sector > SECTOR_HALF;

    always_comb begin
        if (sector == SECTOR_LAST) begin
            slot_wide = SECTOR_W'(SLOT_LAST);
        end else if (sector > SECTOR_HALF) begin
            slot_wide = SECTOR_FLIP - sector;
        end else begin
            slot_wide = sector - SECTOR_W'(1);
        end
        slot_next = bad_next ? '0 : slot_wide[SLOT_W-1:0];
    end

    // table loads take effect when the request leaves stage 1
    logic                 s1_move;
    logic                 is_conv;
    logic [PADROW_W-1:0]  idx_wide;
    logic                 row_we;
    logic                 sec_we;
    logic [ROW_AW-1:0]    row_raddr;
    logic [ROW_DATA_W-1:0] row_rdata;
    logic [2*TRIG_W-1:0]  sec_rdata;

    assign s1_move  = v1_reg && r2;
    assign is_conv  = act_reg == ACT_CONVERT;
    assign idx_wide = PADROW_W'(idx_reg);
    assign row_we   = s1_move && (act_reg == ACT_ROW_LOAD) && (idx_wide < ROW_LIM);
    assign sec_we   = s1_move && (act_reg == ACT_SEC_LOAD) &&
                      (idx_reg < IDX_W'(SECTOR_SLOTS));
    assign row_raddr = bad_next ? '0 : row_idx[ROW_AW-1:0];

    th2c_ram #(
        .WIDTH (ROW_DATA_W),
        .DEPTH (ROW_SLOTS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (idx_wide[ROW_AW-1:0]),
        .wdata ({ld_off_reg, ld_cnt_reg, ld_pitch_reg}),
        .re    (r2),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    // running hit number, advanced as each convert request leaves stage 1
    logic [ID_W-1:0] hit_cnt_reg;
    logic [ID_W-1:0] hit_cnt_next;

    assign hit_cnt_next = hit_cnt_reg + ID_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cnt_reg <= '0;
        end else if (s1_move && is_conv) begin
            hit_cnt_reg <= hit_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: decoded hit, row entry comes from the ram read register
    logic [ID_W-1:0]     id2_reg;
    logic [CODE_W-1:0]   code2_reg;
    logic [POS_W-1:0]    pad2_reg;
    logic [POS_W-1:0]    tim2_reg;
    logic [SLOT_W-1:0]   slot2_reg;
    logic                bad2_reg;
    logic                neg2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (r2) begin
            v2_reg <= v1_reg && is_conv;
        end
    end

    always_ff @(posedge aclk) begin
        if (r2) begin
            id2_reg   <= hit_cnt_next;
            code2_reg <= code1_reg;
            pad2_reg  <= pad1_reg;
            tim2_reg  <= tim1_reg;
            slot2_reg <= slot_next;
            bad2_reg  <= bad_next;
            neg2_reg  <= neg_next;
        end
    end

    // sector rotation table, read as the hit enters stage 3
    th2c_ram #(
        .WIDTH (2*TRIG_W),
        .DEPTH (SECTOR_SLOTS)
    ) u_sec_ram (
        .aclk  (aclk),
        .we    (sec_we),
        .waddr (idx_reg[SLOT_W-1:0]),
        .wdata ({ld_sin_reg, ld_cos_reg}),
        .re    (r3),
        .raddr (slot2_reg),
        .rdata (sec_rdata)
    );

    // local x, z base and time product
    logic [OFF_W-1:0]          row_off;
    logic [CNT_W-1:0]          row_cnt;
    logic [PITCH_W-1:0]        row_pitch;
    logic signed [FAC_W-1:0]   fac;
    logic signed [XL_W-1:0]    xl_next;
    logic signed [ZB_W-1:0]    zb_next;
    logic [TP_W-1:0]           tp_next;

    assign row_off   = row_rdata[ROW_DATA_W-1 -: OFF_W];
    assign row_cnt   = row_rdata[PITCH_W +: CNT_W];
    assign row_pitch = row_rdata[PITCH_W-1:0];

    assign fac = $signed({2'b00, pad2_reg}) -
                 $signed({5'b00000, row_cnt[CNT_W-1:1], 6'b000000}) + FAC_W'(32);
    assign xl_next = XL_W'(fac) * XL_W'($signed({1'b0, row_pitch}));
    assign zb_next = ZB_W'(z_off_reg) + $signed({2'b00, drift_reg});
    assign tp_next = TP_W'(tim2_reg) * TP_W'(scale_reg);

    // ------------------------------------------------------------------
    // stage 3: local coordinates and trig values
    logic [ID_W-1:0]          id3_reg;
    logic [CODE_W-1:0]        code3_reg;
    logic                     bad3_reg;
    logic                     neg3_reg;
    logic signed [XL_W-1:0]   xl_reg;
    logic [OFF_W-1:0]         off3_reg;
    logic signed [TRIG_W-1:0] sin3;
    logic signed [TRIG_W-1:0] cos3;
    logic signed [ZB_W-1:0]   zb_reg;
    logic [TP_W-1:0]          tp_reg;

    assign sin3 = sec_rdata[2*TRIG_W-1 -: TRIG_W];
    assign cos3 = sec_rdata[TRIG_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (r3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r3) begin
            id3_reg   <= id2_reg;
            code3_reg <= code2_reg;
            bad3_reg  <= bad2_reg;
            neg3_reg  <= neg2_reg;
            xl_reg    <= xl_next;
            off3_reg  <= row_off;
            zb_reg    <= zb_next;
            tp_reg    <= tp_next;
        end
    end

    // rotation products and z difference
    logic signed [PY_W-1:0] off_s;
    logic signed [PX_W-1:0] psx_next, pcx_next;
    logic signed [PY_W-1:0] psy_next, pcy_next;
    logic signed [Z_W-1:0]  zd;
    logic signed [Z_W-1:0]  zg_next;

    assign off_s    = $signed({{(PY_W-OFF_W){1'b0}}, off3_reg});
    assign psx_next = PX_W'(sin3) * PX_W'(xl_reg);
    assign pcx_next = PX_W'(cos3) * PX_W'(xl_reg);
    assign psy_next = PY_W'(sin3) * off_s;
    assign pcy_next = PY_W'(cos3) * off_s;
    assign zd       = (Z_W'(zb_reg) <<< YL_SH) - $signed({{(Z_W-TP_W){1'b0}}, tp_reg});
    assign zg_next  = neg3_reg ? -zd : zd;

    // ------------------------------------------------------------------
    // stage 4: products
    logic [ID_W-1:0]        id4_reg;
    logic [CODE_W-1:0]      code4_reg;
    logic                   bad4_reg;
    logic signed [PX_W-1:0] psx_reg, pcx_reg;
    logic signed [PY_W-1:0] psy_reg, pcy_reg;
    logic signed [Z_W-1:0]  zg4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (r4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r4) begin
            id4_reg   <= id3_reg;
            code4_reg <= code3_reg;
            bad4_reg  <= bad3_reg;
            psx_reg   <= psx_next;
            pcx_reg   <= pcx_next;
            psy_reg   <= psy_next;
            pcy_reg   <= pcy_next;
            zg4_reg   <= zg_next;
        end
    end

    // rotated sums in 2^-37 cm
    logic signed [XG_W-1:0] xg_next, yg_next;

    assign xg_next = XG_W'(psx_reg) + (XG_W'(pcy_reg) <<< YL_SH);
    assign yg_next = (XG_W'(psy_reg) <<< YL_SH) - XG_W'(pcx_reg);

    // ------------------------------------------------------------------
    // stage 5: global coordinates before rounding
    logic [ID_W-1:0]        id5_reg;
    logic [CODE_W-1:0]      code5_reg;
    logic                   bad5_reg;
    logic signed [XG_W-1:0] xg_reg, yg_reg;
    logic signed [Z_W-1:0]  zg5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (r5) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r5) begin
            id5_reg   <= id4_reg;
            code5_reg <= code4_reg;
            bad5_reg  <= bad4_reg;
            xg_reg    <= xg_next;
            yg_reg    <= yg_next;
            zg5_reg   <= zg4_reg;
        end
    end

    // round halves up to 1/256 cm and clamp to 24 bits; zero on a range error
    localparam logic signed [XG_W-1:0] XY_HALF = XG_W'(1) <<< (XY_SH - 1);
    localparam logic signed [Z_W-1:0]  Z_HALF  = Z_W'(1) <<< (Z_SH - 1);

    logic signed [XG_W-1:0]  x_shr, y_shr;
    logic signed [Z_W-1:0]   z_shr;
    logic signed [OUT_W-1:0] x_next, y_next, z_next;

    assign x_shr  = (xg_reg + XY_HALF) >>> XY_SH;
    assign y_shr  = (yg_reg + XY_HALF) >>> XY_SH;
    assign z_shr  = (zg5_reg + Z_HALF) >>> Z_SH;
    assign x_next = bad5_reg ? '0 : sat_out(SAT_W'(x_shr));
    assign y_next = bad5_reg ? '0 : sat_out(SAT_W'(y_shr));
    assign z_next = bad5_reg ? '0 : sat_out(SAT_W'(z_shr));

    // ------------------------------------------------------------------
    // output register
    logic [ID_W-1:0]         m_id_reg;
    logic [CODE_W-1:0]       m_code_reg;
    logic signed [OUT_W-1:0] m_x_reg, m_y_reg, m_z_reg;
    logic                    m_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (r_out) begin
            m_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r_out) begin
            m_id_reg   <= id5_reg;
            m_code_reg <= code5_reg;
            m_x_reg    <= x_next;
            m_y_reg    <= y_next;
            m_z_reg    <= z_next;
            m_err_reg  <= bad5_reg;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = {4'b0000, m_z_reg, m_y_reg, m_x_reg, m_code_reg, m_id_reg};
    assign m_axis_tuser[0] = m_err_reg;

    // ------------------------------------------------------------------
    // checks

    // a range error request carries zero coordinates
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_err_reg) |-> (m_x_reg == '0 && m_y_reg == '0 && m_z_reg == '0))
        else $error("range error result with nonzero coordinates");

    // hit counter steps by one for each convert request leaving stage 1
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_move && is_conv) |=> (hit_cnt_reg == $past(hit_cnt_next)))
        else $error("hit counter did not advance");

    // load requests never enter the arithmetic stages
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_move && !is_conv) |=> !v2_reg)
        else $error("load request passed stage 1");

    // table writes only happen as the load request moves on
    assert property (@(posedge aclk) disable iff (!aresetn)
        (row_we || sec_we) |-> (v1_reg && r2))
        else $error("table write while stage 1 stalled");

endmodule

// File: rtl/th2c_ram.sv
// generic single write port ram with registered read and read enable
`timescale 1ns / 1ps

module th2c_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
